// File: sv/sbsra_pkg.sv
package sbsra_pkg;

  // Default buffer size seen by the host side.
  localparam int BUFFER_BYTES_DEFAULT = 64;

  // Depth of the job queue between the front and the back part.
  localparam int QUEUE_DEPTH = 4;

  // Input item kinds.
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // Output port select.
  localparam logic PORT_BUS  = 1'b0;
  localparam logic PORT_HOST = 1'b1;

  // Packet constants.
  localparam logic [7:0] SYNC_BYTE     = 8'hFF;
  localparam logic [7:0] REQ_PKT_LEN   = 8'd4;
  localparam logic [7:0] INST_READ     = 8'd2;
  localparam logic [7:0] REQ_SUM_BIAS  = 8'd6;
  localparam logic [7:0] HDR_LEN_BIAS  = 8'd2;
  localparam logic [7:0] STATUS_OK     = 8'h00;
  localparam logic [7:0] ERR_BYTE      = 8'h00;
  localparam logic [7:0] BAD_REPLY     = 8'hFF;

  // Jobs handed from the front part to the back part.
  typedef enum logic [2:0] {
    JOB_ERR,
    JOB_HDR,
    JOB_REQ,
    JOB_DATA,
    JOB_DATA_END
  } job_op_t;

  typedef struct packed {
    job_op_t    op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } job_t;

  // One result item.
  typedef struct packed {
    logic       port;
    logic [7:0] data;
    logic       err;
    logic       last;
  } res_t;

  // Index of the final byte of a job.
  function automatic logic [2:0] job_last_idx(job_op_t op);
    logic [2:0] n;
    case (op)
      JOB_HDR:      n = 3'd4;
      JOB_REQ:      n = 3'd7;
      JOB_DATA_END: n = 3'd1;
      default:      n = 3'd0;
    endcase
    return n;
  endfunction

  // Byte number idx of a job.
  function automatic res_t job_byte(job_t j, logic [2:0] idx);
    res_t r;
    r.port = PORT_HOST;
    r.data = ERR_BYTE;
    r.err  = 1'b0;
    r.last = (idx == job_last_idx(j.op));
    case (j.op)
      JOB_ERR: begin
        r.err = 1'b1;
      end
      JOB_HDR: begin
        case (idx)
          3'd0, 3'd1: r.data = SYNC_BYTE;
          3'd2:       r.data = j.b0;
          3'd3:       r.data = j.b1;
          default:    r.data = STATUS_OK;
        endcase
      end
      JOB_REQ: begin
        r.port = PORT_BUS;
        case (idx)
          3'd0, 3'd1: r.data = SYNC_BYTE;
          3'd2:       r.data = j.b0;
          3'd3:       r.data = REQ_PKT_LEN;
          3'd4:       r.data = INST_READ;
          3'd5:       r.data = j.b1;
          3'd6:       r.data = j.b2;
          default:    r.data = j.b3;
        endcase
      end
      JOB_DATA_END: begin
        r.data = (idx == 3'd0) ? j.b0 : j.b1;
      end
      default: begin
        r.data = j.b0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: sv/sbsra_front.sv
module sbsra_front #(
  parameter int BUFFER_BYTES = sbsra_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [7:0]        host_id,
  input  logic [7:0]        start_address,
  input  logic [7:0]        read_length,
  input  logic [7:0]        param_count,
  input  logic [7:0]        target_id,
  input  logic              reply_ok,
  input  logic [7:0]        reply_byte,
  input  logic              q_full,
  output logic              push,
  output sbsra_pkg::job_t   push_job
);

  localparam logic [7:0] LIMIT = 8'(BUFFER_BYTES - 6);

  // Transfer state.
  logic [7:0] host_checksum, host_checksum_next;
  logic [7:0] address_in_use, address_in_use_next;
  logic [7:0] length_in_use, length_in_use_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic       transfer_active, transfer_active_next;

  logic        in_fire;
  logic [7:0]  servos;
  logic [15:0] total;
  logic        bad_cmd;
  logic [7:0]  data_byte;
  logic [7:0]  sum_after;
  logic [7:0]  left_after;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // Command checks: servo count wraps as a byte.
  assign servos  = param_count - 8'd2;
  assign total   = 16'(read_length) * 16'(servos);
  assign bad_cmd = (read_length == 8'd0) || (servos == 8'd0) ||
                   (read_length > LIMIT) || (total > 16'(LIMIT));

  // Reply byte handling.
  assign data_byte  = reply_ok ? reply_byte : sbsra_pkg::BAD_REPLY;
  assign sum_after  = host_checksum + data_byte;
  assign left_after = bytes_remaining - 8'd1;

  // Classify the item, update the transfer state and build the job.
  always_comb begin
    host_checksum_next   = host_checksum;
    address_in_use_next  = address_in_use;
    length_in_use_next   = length_in_use;
    bytes_remaining_next = bytes_remaining;
    transfer_active_next = transfer_active;
    push                 = 1'b0;
    push_job.op          = sbsra_pkg::JOB_DATA;
    push_job.b0          = data_byte;
    push_job.b1          = ~sum_after;
    push_job.b2          = length_in_use;
    push_job.b3          = ~(target_id + sbsra_pkg::REQ_SUM_BIAS +
                             address_in_use + length_in_use);
    if (in_fire) begin
      case (kind)
        sbsra_pkg::KIND_CMD: begin
          push                 = 1'b1;
          transfer_active_next = 1'b0;
          if (bad_cmd) begin
            bytes_remaining_next = 8'd0;
            push_job.op          = sbsra_pkg::JOB_ERR;
          end else begin
            address_in_use_next  = start_address;
            length_in_use_next   = read_length;
            bytes_remaining_next = total[7:0];
            host_checksum_next   = host_id + total[7:0] + sbsra_pkg::HDR_LEN_BIAS;
            transfer_active_next = 1'b1;
            push_job.op          = sbsra_pkg::JOB_HDR;
            push_job.b0          = host_id;
            push_job.b1          = total[7:0] + sbsra_pkg::HDR_LEN_BIAS;
          end
        end
        sbsra_pkg::KIND_REQ: begin
          push        = transfer_active;
          push_job.op = sbsra_pkg::JOB_REQ;
          push_job.b0 = target_id;
          push_job.b1 = address_in_use;
        end
        sbsra_pkg::KIND_DATA: begin
          if (transfer_active) begin
            push                 = 1'b1;
            host_checksum_next   = sum_after;
            bytes_remaining_next = left_after;
            if (left_after == 8'd0) begin
              transfer_active_next = 1'b0;
              push_job.op          = sbsra_pkg::JOB_DATA_END;
            end
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      host_checksum   <= 8'd0;
      address_in_use  <= 8'd0;
      length_in_use   <= 8'd0;
      bytes_remaining <= 8'd0;
      transfer_active <= 1'b0;
    end else begin
      host_checksum   <= host_checksum_next;
      address_in_use  <= address_in_use_next;
      length_in_use   <= length_in_use_next;
      bytes_remaining <= bytes_remaining_next;
      transfer_active <= transfer_active_next;
    end
  end

endmodule

// File: sv/sbsra_queue.sv
module sbsra_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sbsra_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output sbsra_pkg::job_t q_job
);

  localparam int DEPTH = sbsra_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  sbsra_pkg::job_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign q_job   = slots[rd_ptr];

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// File: sv/sbsra_back.sv
module sbsra_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sbsra_pkg::job_t q_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            port,
  output logic [7:0]      out_byte,
  output logic            range_error,
  output logic            last
);

  sbsra_pkg::job_t cur;
  logic            cur_valid;
  logic [2:0]      idx;
  sbsra_pkg::res_t res;
  logic            out_load;
  logic            cur_done;

  assign res      = sbsra_pkg::job_byte(cur, idx);
  assign out_load = !out_valid || out_ready;
  assign cur_done = cur_valid && out_load && res.last;
  assign pop      = q_valid && (!cur_valid || cur_done);

  // Current job and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (!cur_valid || cur_done) begin
      cur_valid <= q_valid;
      idx       <= 3'd0;
    end else if (out_load) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && cur_valid) begin
      port        <= res.port;
      out_byte    <= res.data;
      range_error <= res.err;
      last        <= res.last;
    end
  end

  // A rejected command is always a single zero byte to the host.
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last && (out_byte == 8'd0) && port)
    else $error("range error item is malformed");

  // The byte counter never runs past the end of the current job.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= sbsra_pkg::job_last_idx(cur.op))
    else $error("byte counter past end of job");

  // A job is only taken from the queue when one is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// File: sv/servo_bus_sync_read_aggregator_top.sv
// Sync-read bridge between a host and a servo bus. Items of kind 0 (host
// command), 1 (servo request) and 2 (servo reply byte) are taken at up to one
// per cycle while the four-entry job queue has room; each yields a host reply
// header, an 8-byte read request, a forwarded byte, or a range error. The
// output side sends one byte per cycle while out_ready is high, so the rate
// is set by the bytes of each item: 8 per servo request, 5 per header, 1 per
// reply byte (2 for the final one, which carries the host checksum). Items go
// through the job queue, the current-job register and the output register.
module servo_bus_sync_read_aggregator_top #(
  parameter int BUFFER_BYTES = sbsra_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] host_id,
  input  logic [7:0] start_address,
  input  logic [7:0] read_length,
  input  logic [7:0] param_count,
  input  logic [7:0] target_id,
  input  logic       reply_ok,
  input  logic [7:0] reply_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       port,
  output logic [7:0] out_byte,
  output logic       range_error,
  output logic       last
);

  logic            q_full;
  logic            push;
  sbsra_pkg::job_t push_job;
  logic            pop;
  logic            q_valid;
  sbsra_pkg::job_t q_job;

  sbsra_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .host_id      (host_id),
    .start_address(start_address),
    .read_length  (read_length),
    .param_count  (param_count),
    .target_id    (target_id),
    .reply_ok     (reply_ok),
    .reply_byte   (reply_byte),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  sbsra_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  sbsra_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .port       (port),
    .out_byte   (out_byte),
    .range_error(range_error),
    .last       (last)
  );

endmodule
